// ===== hw/rtl/uartrx_pkg.sv =====
package uartrx_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned ADDR_W    = 3;
  localparam int unsigned FRAME_W   = 10;
  localparam int unsigned INDEX_W   = 4;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned DIV_STEPS = DATA_W;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  localparam logic [INDEX_W-1:0] LAST_BIT = INDEX_W'(9);
  localparam logic [DATA_W-1:0]  BIT_TIME_RESET = DATA_W'(8333);

  localparam logic REG_BIT_TIME = 1'b0;
  localparam logic REG_INVERT   = 1'b1;

  typedef struct packed {
    logic [DATA_W-1:0] bit_time;
    logic              invert_line;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic               big;
    logic [INDEX_W-1:0] quot;
  } div_res_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } emit_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

endpackage

// ===== hw/rtl/uart_rx_edge_time_decoder.sv =====
// 8N1 serial receiver fed with line-change requests (cycle stamp and new pin level)
// rather than line samples. A falling edge while idle opens a frame.
// Every other edge is timed against the frame start by a radix-2 shift-subtract
// divider, one quotient bit per cycle; no further edge is taken until the load,
// the 32 divider steps and the decision are through. A received byte sits in an
// output register on byte_valid/byte_ready; the decoder only waits for it when the
// following edge completes another byte. The user must write bit_time (address 0)
// and invert_line (address 4) over the APB port only while idle; not enforced here.
module uart_rx_edge_time_decoder
  import uartrx_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              edge_valid,
  output logic              edge_ready,
  input  logic [DATA_W-1:0] edge_time,
  input  logic              pin_level,
  output logic              byte_valid,
  input  logic              byte_ready,
  output logic [BYTE_W-1:0] rx_byte
);

  cfg_t     cfg;
  div_req_t div_req;
  div_res_t div_res;
  emit_t    emit;
  logic     out_free;

  uartrx_apb u_apb (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  uartrx_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .res (div_res)
  );

  uartrx_frame u_frame (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .edge_valid (edge_valid),
    .edge_ready (edge_ready),
    .edge_time  (edge_time),
    .pin_level  (pin_level),
    .out_free   (out_free),
    .div_req    (div_req),
    .div_res    (div_res),
    .emit       (emit)
  );

  assign out_free = ~byte_valid | byte_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (emit.valid) begin
      byte_valid <= 1'b1;
    end else if (byte_ready) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      rx_byte <= emit.data;
    end
  end

endmodule

// ===== hw/rtl/uartrx_apb.sv =====
module uartrx_apb
  import uartrx_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [DATA_W-1:0] bit_time;
  logic              invert_line;
  logic              wr_en;
  logic              reg_sel;

  // word registers, byte lane bits ignored
  assign reg_sel = paddr[2];
  assign wr_en   = psel & penable & pwrite & pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_time    <= BIT_TIME_RESET;
      invert_line <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_BIT_TIME: bit_time    <= pwdata;
        REG_INVERT:   invert_line <= pwdata[0];
        default:      bit_time    <= bit_time;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_BIT_TIME: prdata = bit_time;
      REG_INVERT:   prdata = {{(DATA_W-1){1'b0}}, invert_line};
      default:      prdata = '0;
    endcase
  end

  assign cfg.bit_time    = bit_time;
  assign cfg.invert_line = invert_line;

endmodule

// ===== hw/rtl/uartrx_div.sv =====
module uartrx_div
  import uartrx_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_res_t res
);

  logic [DATA_W-1:0]  dvd;
  logic [DATA_W-1:0]  rem;
  logic [DATA_W-1:0]  dsr;
  logic [INDEX_W-1:0] quot;
  logic               big;
  logic [STEP_W-1:0]  step;
  logic               busy;
  logic               done;
  logic [DATA_W+1:0]  trial;
  logic               fits;

  // one quotient bit per cycle, dividend shifts out msb first
  assign trial = {1'b0, rem, dvd[DATA_W-1]} - {2'b00, dsr};
  assign fits  = ~trial[DATA_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= ~req.start & busy & (step == STEP_W'(DIV_STEPS - 1));
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd  <= req.dividend;
      dsr  <= req.divisor;
      rem  <= '0;
      quot <= '0;
      big  <= 1'b0;
    end else if (busy) begin
      dvd  <= {dvd[DATA_W-2:0], 1'b0};
      rem  <= fits ? trial[DATA_W-1:0] : {rem[DATA_W-2:0], dvd[DATA_W-1]};
      // quotient keeps its low bits, big flags any overflow; only small values matter
      quot <= {quot[INDEX_W-2:0], fits};
      big  <= big | quot[INDEX_W-1];
    end
  end

  assign res.done = done;
  assign res.big  = big;
  assign res.quot = quot;

endmodule

// ===== hw/rtl/uartrx_frame.sv =====
module uartrx_frame
  import uartrx_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              edge_valid,
  output logic              edge_ready,
  input  logic [DATA_W-1:0] edge_time,
  input  logic              pin_level,
  input  logic              out_free,
  output div_req_t          div_req,
  input  div_res_t          div_res,
  output emit_t             emit
);

  state_t             state;
  state_t             state_next;
  logic [DATA_W-1:0]  frame_origin;
  logic [FRAME_W-1:0] frame_bits;
  logic [INDEX_W-1:0] bit_index;
  logic [DATA_W-1:0]  edge_stamp;
  logic               edge_level;

  logic               take;
  logic               level;
  logic               open_now;
  logic [DATA_W-1:0]  quarter;
  logic               past_last;
  logic               at_last;
  logic               restart;
  logic               finish;
  logic               stall;
  logic [FRAME_W-1:0] fill_tail;
  logic [FRAME_W-1:0] fill_span;

  assign quarter    = {2'b00, cfg.bit_time[DATA_W-1:2]};
  assign edge_ready = (state == ST_IDLE);
  assign take       = edge_valid & edge_ready;
  assign level      = pin_level ^ cfg.invert_line;
  assign open_now   = ~level & (bit_index == '0);

  assign past_last = div_res.big | (div_res.quot > LAST_BIT);
  assign at_last   = div_res.big | (div_res.quot >= LAST_BIT);
  assign restart   = ~edge_level & past_last;
  assign finish    = restart | at_last;
  assign stall     = finish & ~out_free;

  always_comb begin
    for (int k = 0; k < FRAME_W; k++) begin
      fill_tail[k] = (INDEX_W'(k) >= bit_index);
      fill_span[k] = (INDEX_W'(k) >= bit_index) && (INDEX_W'(k) < div_res.quot);
    end
  end

  assign div_req.start    = take & ~open_now;
  assign div_req.dividend = edge_time - frame_origin;
  assign div_req.divisor  = cfg.bit_time;

  assign emit.valid = (state == ST_DONE) & finish & out_free;
  assign emit.data  = restart ? (frame_bits[BYTE_W:1] | fill_tail[BYTE_W:1])
                              : frame_bits[BYTE_W:1];

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (take && !open_now) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_res.done) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      frame_origin <= '0;
      frame_bits   <= '0;
      bit_index    <= '0;
    end else begin
      state <= state_next;
      if (take && open_now) begin
        frame_origin <= edge_time - quarter;
        frame_bits   <= '0;
        bit_index    <= INDEX_W'(1);
      end else if (state == ST_DONE && !stall) begin
        if (restart) begin
          frame_origin <= edge_stamp - quarter;
          frame_bits   <= '0;
          bit_index    <= INDEX_W'(1);
        end else if (at_last) begin
          frame_bits <= '0;
          bit_index  <= '0;
        end else begin
          if (!edge_level) frame_bits <= frame_bits | fill_span;
          bit_index <= div_res.quot;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      edge_stamp <= edge_time;
      edge_level <= level;
    end
  end

endmodule

// ===== sim/uart_rx_edge_time_decoder_tb.sv =====
`timescale 1ns / 100ps

module uart_rx_edge_time_decoder_tb;
  import uartrx_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 48;
  localparam int unsigned HOLD_CYCLES   = 4000;
  localparam int unsigned PHASE_EDGES   = 240;

  typedef struct {
    logic [DATA_W-1:0] stamp;
    logic              pin;
  } line_event_t;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_PATTERN,
    RDY_SPARSE
  } ready_mode_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              edge_valid = 1'b0;
  logic              edge_ready;
  logic [DATA_W-1:0] edge_time = '0;
  logic              pin_level = 1'b0;
  logic              byte_valid;
  logic              byte_ready = 1'b0;
  logic [BYTE_W-1:0] rx_byte;

  uart_rx_edge_time_decoder uut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .edge_valid (edge_valid),
    .edge_ready (edge_ready),
    .edge_time  (edge_time),
    .pin_level  (pin_level),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .rx_byte    (rx_byte)
  );

  // line settings as last written
  logic [DATA_W-1:0]  cfg_bit_time = BIT_TIME_RESET;
  logic               cfg_invert = 1'b0;

  // decoder state tracked alongside the block
  logic [DATA_W-1:0]  track_origin = '0;
  logic [FRAME_W-1:0] track_bits = '0;
  logic [INDEX_W-1:0] track_index = '0;

  line_event_t        pending_edges[$];
  logic [BYTE_W-1:0]  expected_bytes[$];

  logic [DATA_W-1:0]  stamp_now = '0;
  int unsigned        edges_queued = 0;
  int unsigned        edges_taken = 0;
  int unsigned        bytes_checked = 0;
  int unsigned        settings_run = 1;
  int unsigned        errors = 0;

  int unsigned        burst_left = 0;
  int unsigned        gap_left = 0;
  line_event_t        next_edge;
  logic [BYTE_W-1:0]  byte_out;
  logic [BYTE_W-1:0]  byte_want;

  ready_mode_t        ready_mode = RDY_ALWAYS;
  int unsigned        mode_left = 0;
  logic [7:0]         ready_pat = 8'hff;
  logic               hold_go = 1'b0;
  logic               hold_active = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // returns 1 when the edge completes a byte
  function automatic bit decode_edge(input logic [DATA_W-1:0] stamp, input logic pin,
                                     output logic [BYTE_W-1:0] data);
    logic              level;
    logic [DATA_W-1:0] quot;
    int                k;
    level = pin ^ cfg_invert;
    data = '0;
    if (!level && track_index == 0) begin
      track_origin = stamp - (cfg_bit_time >> 2);
      track_bits = '0;
      track_index = INDEX_W'(1);
      return 1'b0;
    end
    quot = (cfg_bit_time == 0) ? '1 : (stamp - track_origin) / cfg_bit_time;
    if (!level && quot > LAST_BIT) begin
      for (k = track_index; k <= LAST_BIT; k++)
        track_bits[k] = 1'b1;
      data = track_bits[BYTE_W:1];
      track_origin = stamp - (cfg_bit_time >> 2);
      track_bits = '0;
      track_index = INDEX_W'(1);
      return 1'b1;
    end
    if (quot >= LAST_BIT) begin
      data = track_bits[BYTE_W:1];
      track_bits = '0;
      track_index = '0;
      return 1'b1;
    end
    if (!level) begin
      for (k = track_index; k < quot; k++)
        track_bits[k] = 1'b1;
    end
    track_index = quot[INDEX_W-1:0];
    return 1'b0;
  endfunction

  // line level as the decoder sees it, turned into the pin level to drive
  task automatic push_edge(input logic [DATA_W-1:0] stamp, input logic level);
    line_event_t ev;
    ev.stamp = stamp;
    ev.pin = level ^ cfg_invert;
    pending_edges.push_back(ev);
    edges_queued++;
  endtask

  // 8N1 frame from stamp_now, only the first keep edges are sent
  task automatic push_frame(input logic [BYTE_W-1:0] data, input logic [DATA_W-1:0] gap,
                            input int keep);
    logic [FRAME_W-1:0] line;
    logic [DATA_W-1:0]  t0;
    int                 k;
    int                 sent;
    line = {1'b1, data, 1'b0};
    t0 = stamp_now;
    sent = 1;
    push_edge(t0, 1'b0);
    for (k = 1; k <= LAST_BIT; k++) begin
      if (line[k] != line[k-1] && sent < keep) begin
        push_edge(t0 + k * cfg_bit_time + $urandom_range(0, cfg_bit_time >> 3), line[k]);
        sent++;
      end
    end
    stamp_now = t0 + 10 * cfg_bit_time + gap;
  endtask

  task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_line(input logic [DATA_W-1:0] bit_time, input logic invert);
    apb_write({REG_BIT_TIME, 2'b00}, bit_time);
    apb_write({REG_INVERT, 2'b00}, DATA_W'(invert));
    cfg_bit_time = bit_time;
    cfg_invert = invert;
    settings_run++;
  endtask

  task automatic wait_idle;
    do begin
      do @(posedge clk);
      while (pending_edges.size() != 0 || edge_valid || expected_bytes.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clk);
    end while (pending_edges.size() != 0 || edge_valid || expected_bytes.size() != 0);
  endtask

  task automatic random_phase(input logic [DATA_W-1:0] bit_time, input logic invert);
    int unsigned target;
    int unsigned pick;
    set_line(bit_time, invert);
    target = edges_queued + PHASE_EDGES;
    while (edges_queued < target) begin
      pick = $urandom_range(0, 9);
      if (pick <= 6)
        push_frame(8'($urandom),
                   ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3 * bit_time), 10);
      else if (pick == 7)
        push_frame(8'($urandom), $urandom_range(0, bit_time), $urandom_range(1, 4));
      else if (pick == 8)
        push_edge($urandom, 1'($urandom_range(0, 1)));
      else
        push_edge(stamp_now + $urandom_range(0, 12 * bit_time), 1'($urandom_range(0, 1)));
    end
    wait_idle();
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      edge_valid <= 1'b0;
      edge_time <= '0;
      pin_level <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (edge_valid && edge_ready) begin
        edges_taken++;
        if (decode_edge(edge_time, pin_level, byte_out))
          expected_bytes.push_back(byte_out);
      end
      if (!edge_valid || edge_ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          edge_valid <= 1'b0;
        end else if (pending_edges.size() != 0) begin
          next_edge = pending_edges.pop_front();
          edge_valid <= 1'b1;
          edge_time <= next_edge.stamp;
          pin_level <= next_edge.pin;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          edge_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and byte check
  always @(posedge clk) begin
    if (rst) begin
      byte_ready <= 1'b0;
      mode_left <= 0;
    end else begin
      if (byte_valid && byte_ready) begin
        if (expected_bytes.size() == 0) begin
          errors++;
          $display("%0t: rx_byte expected none, actual %02h", $time, rx_byte);
        end else begin
          byte_want = expected_bytes.pop_front();
          bytes_checked++;
          if (rx_byte !== byte_want) begin
            errors++;
            $display("%0t: rx_byte expected %02h, actual %02h", $time, byte_want, rx_byte);
          end
        end
      end
      if (mode_left == 0) begin
        ready_mode <= ready_mode_t'($urandom_range(0, 3));
        mode_left <= $urandom_range(16, 300);
        ready_pat <= 8'($urandom);
      end else begin
        mode_left <= mode_left - 1;
        ready_pat <= {ready_pat[6:0], ready_pat[7]};
      end
      case (ready_mode)
        RDY_ALWAYS:  byte_ready <= !hold_active;
        RDY_COIN:    byte_ready <= !hold_active && ($urandom_range(0, 1) == 1);
        RDY_PATTERN: byte_ready <= !hold_active && ready_pat[7];
        default:     byte_ready <= !hold_active && ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // long receiver hold-off
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active <= 1'b0;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset settings: stop-bit edge at exactly bit 9 with bits left unfilled
    push_edge(32'h0000_0000, 1'b0);
    push_edge(BIT_TIME_RESET + 100, 1'b1);
    push_edge(9 * BIT_TIME_RESET + 100, 1'b0);
    // rising and late edges while idle use the stale origin
    push_edge(32'hffff_ffff, 1'b1);
    push_edge(32'h0000_0000, 1'b1);
    // frames across the counter wrap
    stamp_now = 32'hffff_f000;
    push_frame(8'hff, 0, 10);
    push_frame(8'h00, BIT_TIME_RESET, 10);
    push_frame(8'ha5, 3 * BIT_TIME_RESET, 10);
    push_frame(8'h5a, 0, 10);
    // time going backwards
    push_edge(stamp_now, 1'b0);
    push_edge(stamp_now + 5 * BIT_TIME_RESET, 1'b1);
    push_edge(stamp_now + 2 * BIT_TIME_RESET, 1'b0);
    push_edge(stamp_now - 1000, 1'b1);
    wait_idle();

    // zero bit time: every timed edge lands past the last bit
    set_line('0, 1'b0);
    push_edge(32'h1234_5678, 1'b0);
    push_edge(32'h1234_5680, 1'b1);
    push_edge(32'h0000_0010, 1'b0);
    push_edge(32'hffff_fff0, 1'b0);
    push_edge(32'h8000_0000, 1'b1);
    wait_idle();

    random_phase(BIT_TIME_RESET, 1'b1);
    hold_go = 1'b1;
    random_phase(32'd4, 1'b0);
    random_phase(32'd4, 1'b1);
    random_phase(32'hffff_ffff, 1'b0);
    random_phase($urandom_range(5, 200000), 1'b0);
    random_phase($urandom_range(5, 200000), 1'b1);
    random_phase($urandom_range(4, 64), 1'b0);
    random_phase(BIT_TIME_RESET, 1'b0);

    $display("line edges sent %0d over %0d line settings, inverted and plain, zero bit time",
             edges_taken, settings_run);
    $display("bytes compared %0d, mismatches %0d", bytes_checked, errors);
    if (errors == 0)
      $display("[uart_rx_edge_time_decoder] OK");
    else
      $display("[uart_rx_edge_time_decoder] ERROR");
    $finish;
  end

  initial begin
    #8_000_000;
    $display("%0t: timeout with %0d requests pending and %0d bytes outstanding", $time,
             pending_edges.size(), expected_bytes.size());
    $display("[uart_rx_edge_time_decoder] ERROR");
    $finish;
  end

endmodule
